>>> rtl/core/wtrg_pkg.sv
// Shared types, constants and helpers for the weighted table random gate.
package wtrg_pkg;

   localparam int NODES     = 16;
   localparam int MAX_DIM   = 4;
   localparam int ROWS      = 16;
   localparam int COLS      = 16;
   localparam int ROW_W     = 4;
   localparam int COL_W     = 4;
   localparam int WEIGHT_W  = 8;
   localparam int SUM_W     = 12;
   localparam int STATE_W   = 16;
   localparam int RAND_W    = 31;
   localparam int CNT_W     = 3;
   localparam int MAP_W     = 16;
   localparam int NIB_W     = 4;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int WT_DEPTH  = ROWS * COLS;
   localparam int WT_AW     = ROW_W + COL_W;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_EVAL  = 1'b1
   } command_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INPUT_COUNT  = 2'd0,
      CSR_OUTPUT_COUNT = 2'd1,
      CSR_INPUT_MAP    = 2'd2,
      CSR_OUTPUT_MAP   = 2'd3
   } csr_index_type;

   // counts above MAX_DIM saturate
   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
      logic [CNT_W-1:0] res;
      res = c;
      if (int'(c) > MAX_DIM) begin
         res = CNT_W'(MAX_DIM);
      end
      return res;
   endfunction

   // node indices at or above NODES do not exist
   function automatic logic node_ok(input logic [NIB_W-1:0] node);
      return int'(node) < NODES;
   endfunction

endpackage

>>> rtl/core/wtrg_req_if.sv
// Request channel: table write or gate evaluate beats.
interface wtrg_req_if;
   logic                                  valid;
   logic                                  ready;
   wtrg_pkg::command_type                 command;
   logic [wtrg_pkg::ROW_W-1:0]            row;
   logic [wtrg_pkg::COL_W-1:0]            column;
   logic [wtrg_pkg::WEIGHT_W-1:0]         weight;
   logic [wtrg_pkg::STATE_W-1:0]          node_states;
   logic [wtrg_pkg::RAND_W-1:0]           random_value;

   modport source (output valid, command, row, column, weight, node_states, random_value,
                   input ready);
   modport sink   (input valid, command, row, column, weight, node_states, random_value,
                   output ready);
endinterface

>>> rtl/core/wtrg_rsp_if.sv
// Response channel: one beat per evaluate.
interface wtrg_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [wtrg_pkg::STATE_W-1:0]    node_mask;
   logic [wtrg_pkg::COL_W-1:0]      chosen_column;
   logic                            bad_row;

   modport source (output valid, node_mask, chosen_column, bad_row, input ready);
   modport sink   (input valid, node_mask, chosen_column, bad_row, output ready);
endinterface

>>> rtl/core/weighted_table_random_gate.sv
// Weighted table random gate: weight RAM, row-sum RAM, serial modulo, column walk.
// Write beat: accepted, then a read-modify-write in ST_WRITE, then back to ST_IDLE.
// Evaluate beat: row-sum read in ST_SUM, restoring modulo in ST_DIV (one dividend bit per
//   cycle), column walk in ST_WALK (one weight RAM read per cycle), then ST_DONE loads the
//   output register once it drains; a row sum below 2 skips the modulo and the walk.
// Sync reset sets config defaults, clears control and the per-entry valid bits; no clear pass.
module weighted_table_random_gate (
   input  logic                               clock,
   input  logic                               reset,
   wtrg_req_if.sink                           req_ch,
   wtrg_rsp_if.source                         rsp_ch,
   input  logic                               csr_we,
   input  logic [wtrg_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wtrg_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int ACC_W   = wtrg_pkg::SUM_W + 1;
   localparam int DCNT_W  = $clog2(wtrg_pkg::RAND_W);
   localparam int SUM_AW  = wtrg_pkg::ROW_W;

   // one-hot sequencer
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_WRITE = 6'b000010,
      ST_SUM   = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_WALK  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [wtrg_pkg::CNT_W-1:0] in_cnt_ff, out_cnt_ff;
   logic [wtrg_pkg::MAP_W-1:0] in_map_ff, out_map_ff;

   // per-item working registers
   logic [wtrg_pkg::ROW_W-1:0]    row_ff, row_in;     // write row or gathered row index
   logic [wtrg_pkg::COL_W-1:0]    col_ff, col_in;     // write column or walk column
   logic [wtrg_pkg::WEIGHT_W-1:0] wgt_ff, wgt_in;
   logic [wtrg_pkg::RAND_W-1:0]   rnd_ff, rnd_in;     // dividend, shifted out MSB first
   logic [wtrg_pkg::SUM_W-1:0]    div_ff, div_in;     // row sum minus one
   logic [ACC_W-1:0]              acc_ff, acc_in;     // remainder, then draw r
   logic [DCNT_W-1:0]             cnt_ff, cnt_in;
   logic                          bad_ff, bad_in;

   // valid bits: an entry never written reads as zero
   logic [wtrg_pkg::WT_DEPTH-1:0] wt_vld_ff;
   logic [wtrg_pkg::ROWS-1:0]     sum_vld_ff;
   logic                          wt_rv_ff, sum_rv_ff;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [wtrg_pkg::STATE_W-1:0]  rsp_mask_ff, rsp_mask_in;
   logic [wtrg_pkg::COL_W-1:0]    rsp_col_ff, rsp_col_in;
   logic                          rsp_bad_ff, rsp_bad_in;

   // RAM ports
   logic [wtrg_pkg::WT_AW-1:0]    wt_rd_addr, wt_wr_addr;
   logic [wtrg_pkg::WEIGHT_W-1:0] wt_q, wt_rd;
   logic                          wt_we;
   logic [SUM_AW-1:0]             sum_rd_addr, sum_wr_addr;
   logic [wtrg_pkg::SUM_W-1:0]    sum_q, sum_rd, sum_wr_data;
   logic                          sum_we;

   logic                          req_ready;
   logic                          req_take;
   logic [wtrg_pkg::ROW_W-1:0]    gather_idx;
   logic [wtrg_pkg::STATE_W-1:0]  scatter_mask;
   logic [ACC_W-1:0]              div_shift, div_rem;

   wtrg_ram #(
      .WIDTH (wtrg_pkg::WEIGHT_W),
      .DEPTH (wtrg_pkg::WT_DEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (wt_we),
      .wr_addr (wt_wr_addr),
      .wr_data (wgt_ff),
      .rd_addr (wt_rd_addr),
      .rd_data (wt_q)
   );

   wtrg_ram #(
      .WIDTH (wtrg_pkg::SUM_W),
      .DEPTH (wtrg_pkg::ROWS)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (sum_we),
      .wr_addr (sum_wr_addr),
      .wr_data (sum_wr_data),
      .rd_addr (sum_rd_addr),
      .rd_data (sum_q)
   );

   assign wt_rd  = wt_rv_ff  ? wt_q  : '0;
   assign sum_rd = sum_rv_ff ? sum_q : '0;

   // handshake: one item in flight; output register decouples the response side
   assign req_ready     = (state_ff == ST_IDLE) && !reset;
   assign req_ch.ready  = req_ready;
   assign req_take      = req_ch.valid && req_ready;

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.node_mask     = rsp_mask_ff;
   assign rsp_ch.chosen_column = rsp_col_ff;
   assign rsp_ch.bad_row       = rsp_bad_ff;

   // gather configured node bits, first input ends up as the most significant gathered bit
   always_comb begin
      logic [wtrg_pkg::NIB_W-1:0] node;
      logic [wtrg_pkg::CNT_W-1:0] n_in;
      logic                       nbit;
      gather_idx = '0;
      n_in       = wtrg_pkg::clamp_count(in_cnt_ff);
      for (int i = 0; i < wtrg_pkg::MAX_DIM; i++) begin
         node = in_map_ff[i*wtrg_pkg::NIB_W +: wtrg_pkg::NIB_W];
         nbit = wtrg_pkg::node_ok(node) ? req_ch.node_states[node] : 1'b0;
         if (i < int'(n_in)) begin
            gather_idx = {gather_idx[wtrg_pkg::ROW_W-2:0], nbit};
         end
      end
   end

   // scatter low column bits to output nodes
   always_comb begin
      logic [wtrg_pkg::NIB_W-1:0] node;
      logic [wtrg_pkg::CNT_W-1:0] n_out;
      scatter_mask = '0;
      n_out        = wtrg_pkg::clamp_count(out_cnt_ff);
      for (int i = 0; i < wtrg_pkg::MAX_DIM; i++) begin
         node = out_map_ff[i*wtrg_pkg::NIB_W +: wtrg_pkg::NIB_W];
         if (i < int'(n_out) && col_ff[i] && wtrg_pkg::node_ok(node)) begin
            scatter_mask[node] = 1'b1;
         end
      end
   end

   // one restoring modulo step; remainder stays below the divisor
   assign div_shift = {acc_ff[wtrg_pkg::SUM_W-1:0], rnd_ff[wtrg_pkg::RAND_W-1]};
   assign div_rem   = (div_shift >= ACC_W'(div_ff)) ? (div_shift - ACC_W'(div_ff)) : div_shift;

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      wgt_in       = wgt_ff;
      rnd_in       = rnd_ff;
      div_in       = div_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      bad_in       = bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_mask_in  = rsp_mask_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_bad_in   = rsp_bad_ff;
      wt_rd_addr   = {row_ff, col_ff};
      sum_rd_addr  = row_ff;
      wt_we        = 1'b0;
      wt_wr_addr   = {row_ff, col_ff};
      sum_we       = 1'b0;
      sum_wr_addr  = row_ff;
      sum_wr_data  = sum_rd - wtrg_pkg::SUM_W'(wt_rd) + wtrg_pkg::SUM_W'(wgt_ff);

      unique case (state_ff)
         ST_IDLE: begin
            // address the RAMs straight from the request so data lands next cycle
            if (req_ch.command == wtrg_pkg::CMD_WRITE) begin
               wt_rd_addr  = {req_ch.row, req_ch.column};
               sum_rd_addr = req_ch.row;
            end else begin
               sum_rd_addr = gather_idx;
            end
            if (req_take) begin
               wgt_in = req_ch.weight;
               rnd_in = req_ch.random_value;
               if (req_ch.command == wtrg_pkg::CMD_WRITE) begin
                  row_in   = req_ch.row;
                  col_in   = req_ch.column;
                  state_in = ST_WRITE;
               end else begin
                  row_in   = gather_idx;
                  col_in   = '0;
                  state_in = ST_SUM;
               end
            end
         end
         ST_WRITE: begin
            // old weight and old sum are on the read ports now
            wt_we    = 1'b1;
            sum_we   = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SUM: begin
            wt_rd_addr = {row_ff, wtrg_pkg::COL_W'(0)};
            col_in     = '0;
            if (sum_rd < wtrg_pkg::SUM_W'(2)) begin
               bad_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               bad_in   = 1'b0;
               div_in   = sum_rd - wtrg_pkg::SUM_W'(1);
               acc_in   = '0;
               cnt_in   = DCNT_W'(wtrg_pkg::RAND_W - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // column 0 weight is fetched during the last step
            wt_rd_addr = {row_ff, wtrg_pkg::COL_W'(0)};
            rnd_in     = {rnd_ff[wtrg_pkg::RAND_W-2:0], 1'b0};
            if (cnt_ff == '0) begin
               acc_in   = div_rem + ACC_W'(1);
               state_in = ST_WALK;
            end else begin
               acc_in = div_rem;
               cnt_in = cnt_ff - DCNT_W'(1);
            end
         end
         ST_WALK: begin
            // weight of col_ff is on the port; prefetch the next column
            wt_rd_addr = {row_ff, col_ff + wtrg_pkg::COL_W'(1)};
            if (col_ff != wtrg_pkg::COL_W'(wtrg_pkg::COLS - 1) && acc_ff > ACC_W'(wt_rd)) begin
               acc_in = acc_ff - ACC_W'(wt_rd);
               col_in = col_ff + wtrg_pkg::COL_W'(1);
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_mask_in  = scatter_mask;
               rsp_col_in   = col_ff;
               rsp_bad_in   = bad_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         wt_vld_ff    <= '0;
         sum_vld_ff   <= '0;
         in_cnt_ff    <= wtrg_pkg::CNT_W'(1);
         out_cnt_ff   <= wtrg_pkg::CNT_W'(1);
         in_map_ff    <= '0;
         out_map_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wt_we) begin
            wt_vld_ff[wt_wr_addr] <= 1'b1;
         end
         if (sum_we) begin
            sum_vld_ff[sum_wr_addr] <= 1'b1;
         end
         if (csr_we) begin
            unique case (wtrg_pkg::csr_index_type'(csr_index))
               wtrg_pkg::CSR_INPUT_COUNT:  in_cnt_ff  <= csr_wdata[wtrg_pkg::CNT_W-1:0];
               wtrg_pkg::CSR_OUTPUT_COUNT: out_cnt_ff <= csr_wdata[wtrg_pkg::CNT_W-1:0];
               wtrg_pkg::CSR_INPUT_MAP:    in_map_ff  <= csr_wdata[wtrg_pkg::MAP_W-1:0];
               wtrg_pkg::CSR_OUTPUT_MAP:   out_map_ff <= csr_wdata[wtrg_pkg::MAP_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      col_ff      <= col_in;
      wgt_ff      <= wgt_in;
      rnd_ff      <= rnd_in;
      div_ff      <= div_in;
      acc_ff      <= acc_in;
      cnt_ff      <= cnt_in;
      bad_ff      <= bad_in;
      rsp_mask_ff <= rsp_mask_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_bad_ff  <= rsp_bad_in;
      wt_rv_ff    <= wt_vld_ff[wt_rd_addr];
      sum_rv_ff   <= sum_vld_ff[sum_rd_addr];
   end

endmodule

>>> rtl/core/wtrg_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module wtrg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/wtrg_checker.sv
// Port-level checks for the weighted table random gate, bound to the top level.
module wtrg_port_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [wtrg_pkg::STATE_W-1:0]       rsp_node_mask,
   input logic [wtrg_pkg::COL_W-1:0]         rsp_chosen_column,
   input logic                               rsp_bad_row
);

   // a stalled response beat holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_node_mask)
         && $stable(rsp_chosen_column) && $stable(rsp_bad_row))
      else $error("response beat changed while stalled");

   // reset empties the output register
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one item in flight: no second accept right after the first
   assert property (@(posedge clock) disable iff (reset)
      !reset && req_valid && req_ready |=> !req_ready)
      else $error("request taken on consecutive cycles");

   // a degenerate row picks column 0 and scatters nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_row |-> rsp_chosen_column == '0 && rsp_node_mask == '0)
      else $error("bad row with nonzero column or mask");

endmodule

bind weighted_table_random_gate wtrg_port_checker u_wtrg_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_node_mask     (rsp_ch.node_mask),
   .rsp_chosen_column (rsp_ch.chosen_column),
   .rsp_bad_row       (rsp_ch.bad_row)
);
